// File: design/min_heap_ready_queue_assert.svh
// Assertion macros for the min-heap ready queue.
// Depends on nothing; included by the modules that check their own logic.
`ifndef MIN_HEAP_READY_QUEUE_ASSERT_SVH
`define MIN_HEAP_READY_QUEUE_ASSERT_SVH
// check that an antecedent implies a consequent in the same cycle
`define MHRQ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// check that an antecedent implies a consequent in the next cycle
`define MHRQ_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// File: design/mhrq_pkg.sv
// Shared types and constants for the min-heap ready queue.
// Depends on nothing.
package mhrq_pkg;
	localparam int HEAP_DEPTH = 64;
	localparam int TAG_BITS   = 16;
	localparam int PRIO_BITS  = 8;
	localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
	localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);
	localparam int ENTRY_BITS = TAG_BITS + PRIO_BITS;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_PREEMPT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic                 found;
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] prio;
		logic                 dropped;
		logic [CNT_BITS-1:0]  total;
	} result_t;
endpackage

// File: design/mhrq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mhrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/mhrq_engine.sv
// Heap sequencer: push, pop and preempt check over the entry RAM.
// Depends on mhrq_pkg, mhrq_ram and min_heap_ready_queue_assert.svh.
`include "min_heap_ready_queue_assert.svh"
module mhrq_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  mhrq_pkg::cmd_t           cmd,
	input  mhrq_pkg::entry_t         in_entry,
	input  logic [mhrq_pkg::PRIO_BITS-1:0] cur_prio,
	output logic                     busy,
	output logic                     done,
	output mhrq_pkg::result_t        result
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_POP_RD0, ST_POP_RDL, ST_POP_GO,
		ST_DN_RDL, ST_DN_RDR, ST_DN_CMP, ST_DONE
	} state_t;

	localparam int AB = mhrq_pkg::ADDR_BITS;
	localparam int CB = mhrq_pkg::CNT_BITS;

	state_t                state_q;
	logic [CB-1:0]         count_q;
	logic [AB-1:0]         pos_q;
	mhrq_pkg::entry_t      cur_q;
	mhrq_pkg::entry_t      left_q;
	mhrq_pkg::entry_t      ret_q;
	logic                  is_preempt_q;
	logic                  popped_q;
	logic                  found_q;
	logic                  dropped_q;
	logic [mhrq_pkg::PRIO_BITS-1:0] curp_q;

	logic                  we;
	logic [AB-1:0]         waddr;
	logic [AB-1:0]         raddr;
	mhrq_pkg::entry_t      wdata;
	mhrq_pkg::entry_t      rdata;
	logic [mhrq_pkg::ENTRY_BITS-1:0] rbits;

	logic [CB:0]           lchild;
	logic [CB:0]           rchild;
	logic [AB-1:0]         parent;

	assign rdata  = mhrq_pkg::entry_t'(rbits);
	assign parent = AB'((pos_q - AB'(1)) >> 1);
	assign lchild = {1'b0, CB'(pos_q)} * (CB+1)'(2) + (CB+1)'(1);
	assign rchild = lchild + (CB+1)'(1);

	mhrq_ram #(.WIDTH(mhrq_pkg::ENTRY_BITS), .DEPTH(mhrq_pkg::HEAP_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rbits)
	);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		case (state_q)
			ST_UP_RD:   raddr = parent;
			ST_UP_CMP: begin
				we = 1'b1;
				if (pos_q != '0 && rdata.prio > cur_q.prio) begin
					wdata = rdata;
				end
			end
			ST_POP_RD0: raddr = '0;
			ST_POP_RDL: raddr = AB'(count_q - CB'(1));
			ST_DN_RDL:  raddr = AB'(lchild);
			ST_DN_RDR:  raddr = AB'(rchild);
			ST_DN_CMP: begin
				we = 1'b1;
				if (lchild < (CB+1)'(count_q) && left_q.prio < cur_q.prio &&
						!(rchild < (CB+1)'(count_q) && rdata.prio < left_q.prio)) begin
					wdata = left_q;
				end else if (rchild < (CB+1)'(count_q) && rdata.prio < cur_q.prio &&
						rdata.prio < left_q.prio) begin
					wdata = rdata;
				end else if (rchild < (CB+1)'(count_q) && rdata.prio < cur_q.prio &&
						!(lchild < (CB+1)'(count_q) && left_q.prio < cur_q.prio)) begin
					wdata = rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			done         <= 1'b0;
			found_q      <= 1'b0;
			dropped_q    <= 1'b0;
			is_preempt_q <= 1'b0;
			popped_q     <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						found_q      <= 1'b0;
						dropped_q    <= 1'b0;
						popped_q     <= 1'b0;
						ret_q        <= '0;
						curp_q       <= cur_prio;
						is_preempt_q <= (cmd == mhrq_pkg::CMD_PREEMPT);
						case (cmd)
							mhrq_pkg::CMD_PUSH: begin
								if (count_q >= CB'(mhrq_pkg::HEAP_DEPTH)) begin
									dropped_q <= 1'b1;
									state_q   <= ST_DONE;
								end else begin
									cur_q   <= in_entry;
									pos_q   <= AB'(count_q);
									count_q <= count_q + CB'(1);
									state_q <= ST_UP_RD;
								end
							end
							mhrq_pkg::CMD_POP, mhrq_pkg::CMD_PREEMPT: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_POP_RD0;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_UP_RD: state_q <= ST_UP_CMP;
				ST_UP_CMP: begin
					if (pos_q != '0 && rdata.prio > cur_q.prio) begin
						pos_q   <= parent;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_POP_RD0: state_q <= ST_POP_RDL;
				ST_POP_RDL: begin
					ret_q    <= rdata;
					popped_q <= 1'b1;
					count_q  <= count_q - CB'(1);
					state_q  <= ST_POP_GO;
				end
				ST_POP_GO: begin
					cur_q <= rdata;
					pos_q <= '0;
					if (count_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DN_RDL;
					end
				end
				ST_DN_RDL: state_q <= ST_DN_RDR;
				ST_DN_RDR: begin
					left_q  <= rdata;
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (lchild < (CB+1)'(count_q) && left_q.prio < cur_q.prio &&
							!(rchild < (CB+1)'(count_q) && rdata.prio < left_q.prio)) begin
						pos_q   <= AB'(lchild);
						state_q <= ST_DN_RDL;
					end else if (rchild < (CB+1)'(count_q) && rdata.prio < cur_q.prio) begin
						pos_q   <= AB'(rchild);
						state_q <= ST_DN_RDL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (is_preempt_q && popped_q && ret_q.prio >= curp_q) begin
						is_preempt_q <= 1'b0;
						popped_q     <= 1'b0;
						cur_q        <= ret_q;
						ret_q        <= '0;
						pos_q        <= AB'(count_q);
						count_q      <= count_q + CB'(1);
						state_q      <= ST_UP_RD;
					end else begin
						found_q <= popped_q;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign result.found   = found_q;
	assign result.tag     = found_q ? ret_q.tag : '0;
	assign result.prio    = found_q ? ret_q.prio : '0;
	assign result.dropped = dropped_q;
	assign result.total   = count_q;

	`MHRQ_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, count_q <= CB'(mhrq_pkg::HEAP_DEPTH))
	`MHRQ_ASSERT_IMP(a_drop_full, clk, arst_n, done && dropped_q, !found_q)
	`MHRQ_ASSERT_NXT(a_done_idle, clk, arst_n, done, !busy || start)
endmodule

// File: design/min_heap_ready_queue.sv
// Top level of the min-heap ready queue: stream ports and result register.
// Depends on mhrq_pkg and mhrq_engine.
// One beat in gives one beat out, and no new beat is taken while a result
// waits. A push moves the new entry up the heap level by level (read the
// parent, compare); a pop or a winning preempt check reads the root and the
// last entry, then moves it down level by level (read both children, compare);
// a losing preempt check then pushes the popped entry back. The result goes
// through the output register. The heap holds 64 entries.
`include "min_heap_ready_queue_assert.svh"
module min_heap_ready_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tuser,   // command[1:0]
	input  logic [31:0] s_tdata,   // proc_tag[15:0], proc_priority[23:16], current_priority[31:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // found[0], out_tag[16:1], out_priority[24:17],
	                               // dropped_full[25], entry_total[32:26]
);
	logic                 busy;
	logic                 done;
	logic                 start;
	mhrq_pkg::result_t    res;
	mhrq_pkg::entry_t     ent;

	assign s_tready = !busy && !m_tvalid && !done;
	assign start    = s_tvalid && s_tready;
	assign ent.tag  = s_tdata[15:0];
	assign ent.prio = s_tdata[23:16];

	mhrq_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (mhrq_pkg::cmd_t'(s_tuser[1:0])),
		.in_entry (ent),
		.cur_prio (s_tdata[31:24]),
		.busy     (busy),
		.done     (done),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata <= {7'd0, res.total, res.dropped, res.prio, res.tag, res.found};
		end
	end

	`MHRQ_ASSERT_IMP(a_no_start_pend, clk, arst_n, m_tvalid, !start)
	`MHRQ_ASSERT_NXT(a_done_valid, clk, arst_n, done, m_tvalid)
	`MHRQ_ASSERT_IMP(a_done_free, clk, arst_n, done, !m_tvalid)
endmodule
